>>> hdl/dsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared widths, entry layouts, memory request bundles and sequencer states
// for the dense shortest path search block.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int NODES          = 16;
  localparam int NODE_BITS      = 4;
  localparam int WEIGHT_BITS    = 16;
  localparam int DIST_BITS      = 24;
  localparam int EDGE_ADDR_BITS = 2 * NODE_BITS;
  localparam int EDGE_DEPTH     = NODES * NODES;

  typedef logic [NODE_BITS-1:0]      node_idx_t;
  typedef logic [DIST_BITS-1:0]      dist_t;
  typedef logic [WEIGHT_BITS-1:0]    weight_t;
  typedef logic [EDGE_ADDR_BITS-1:0] edge_addr_t;
  typedef logic [NODES-1:0]          node_mask_t;

  localparam dist_t DIST_MAX          = '1;
  localparam dist_t REACH_LIMIT_RESET = DIST_BITS'(100000);
  localparam node_idx_t LAST_NODE     = NODE_BITS'(NODES - 1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef struct packed {
    logic    present;
    weight_t weight;
  } edge_entry_t;

  typedef struct packed {
    dist_t     distance;
    node_idx_t pred;
  } node_entry_t;

  typedef struct packed {
    logic        wr_en;
    edge_addr_t  wr_addr;
    edge_entry_t wr_data;
    logic        rd_en;
    edge_addr_t  rd_addr;
  } edge_ram_req_t;

  typedef struct packed {
    logic        wr_en;
    node_idx_t   wr_addr;
    node_entry_t wr_data;
    logic        rd_en;
    node_idx_t   rd_addr;
  } node_ram_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RELAX,
    S_OUT_RD,
    S_OUT_WR
  } seq_state_t;

endpackage

>>> hdl/dsp_edge_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_edge_ram
// Adjacency matrix storage: one weight and present bit per ordered node pair,
// one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dsp_edge_ram
  import dsp_pkg::*;
(
  input  logic          clk,
  input  edge_ram_req_t req,
  output edge_entry_t   rd_data
);

  edge_entry_t mem [EDGE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> hdl/dsp_node_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_node_ram
// Per-node distance and predecessor storage, one write and one registered
// read per cycle. Read data holds until the next read.
// ----------------------------------------------------------------------------
module dsp_node_ram
  import dsp_pkg::*;
(
  input  logic          clk,
  input  node_ram_req_t req,
  output node_entry_t   rd_data
);

  node_entry_t mem [NODES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> hdl/dsp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_seq
// Search sequencer: takes input words, walks the current node's row of the
// edge memory while relaxing and picking the next node, then reports.
// ----------------------------------------------------------------------------
module dsp_seq
  import dsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  dist_t         reach_limit,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          action,
  input  node_idx_t     from_node,
  input  node_idx_t     to_node,
  input  weight_t       edge_weight,
  input  logic          edge_present,
  input  node_idx_t     start_node,
  output logic          out_valid,
  input  logic          out_stall,
  output node_idx_t     node,
  output dist_t         distance,
  output node_idx_t     predecessor,
  output logic          reached,
  output logic          last,
  output edge_ram_req_t edge_req,
  input  edge_entry_t   edge_rd,
  output node_ram_req_t node_req,
  input  node_entry_t   node_rd
);

  seq_state_t state, state_next;
  node_idx_t  cur, cur_next;
  dist_t      cur_dist, cur_dist_next;
  node_idx_t  issue_idx, issue_idx_next;
  logic       issue_done, issue_done_next;
  logic       b_valid, b_valid_next;
  node_idx_t  x_b, x_b_next;
  dist_t      best, best_next;
  logic       found, found_next;
  node_idx_t  next_node, next_node_next;
  node_mask_t visited, visited_next;
  node_mask_t valid_mask, valid_mask_next;
  node_idx_t  out_idx, out_idx_next;
  logic       out_valid_next;
  logic       out_load;

  logic                 in_accept;
  dist_t                old_dist;
  logic [DIST_BITS:0]   sum_wide;
  dist_t                sum_sat;
  logic                 upd;
  dist_t                new_dist;
  logic                 cand;
  dist_t                best_now;
  logic                 found_now;
  node_idx_t            next_now;
  logic                 pass_end;
  node_mask_t           one_hot_cur;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Relaxation of the entry that was read in the previous cycle. Entries not
  // written since the run started read as unreached.
  always_comb begin
    old_dist  = valid_mask[x_b] ? node_rd.distance : DIST_MAX;
    sum_wide  = {1'b0, cur_dist} + (DIST_BITS + 1)'(edge_rd.weight);
    sum_sat   = sum_wide[DIST_BITS] ? DIST_MAX : sum_wide[DIST_BITS-1:0];
    upd       = b_valid && edge_rd.present && (sum_sat < old_dist);
    new_dist  = upd ? sum_sat : old_dist;
    // Each node's distance is final for this pass once its entry goes by, so
    // the next-node pick rides along in the same sweep.
    cand      = b_valid && !visited[x_b] && (x_b != cur) && (new_dist < best);
    best_now  = cand ? new_dist : best;
    found_now = found || cand;
    next_now  = cand ? x_b : next_node;
    pass_end  = b_valid && (x_b == LAST_NODE);
    one_hot_cur = node_mask_t'(1) << cur;
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    cur_dist_next   = cur_dist;
    issue_idx_next  = issue_idx;
    issue_done_next = issue_done;
    b_valid_next    = 1'b0;
    x_b_next        = x_b;
    best_next       = best;
    found_next      = found;
    next_node_next  = next_node;
    visited_next    = visited;
    valid_mask_next = valid_mask;
    out_idx_next    = out_idx;
    out_load        = 1'b0;
    edge_req        = '0;
    node_req        = '0;

    unique case (state)
      S_IDLE: begin
        if (in_accept && action == ACT_LOAD) begin
          edge_req.wr_en           = 1'b1;
          edge_req.wr_addr         = {from_node, to_node};
          edge_req.wr_data.present = edge_present;
          edge_req.wr_data.weight  = edge_weight;
        end else if (in_accept) begin
          node_req.wr_en            = 1'b1;
          node_req.wr_addr          = start_node;
          node_req.wr_data.distance = '0;
          node_req.wr_data.pred     = start_node;
          valid_mask_next = node_mask_t'(1) << start_node;
          visited_next    = '0;
          cur_next        = start_node;
          cur_dist_next   = '0;
          issue_idx_next  = '0;
          issue_done_next = 1'b0;
          best_next       = reach_limit;
          found_next      = 1'b0;
          state_next      = S_RELAX;
        end
      end
      S_RELAX: begin
        if (!issue_done) begin
          edge_req.rd_en   = 1'b1;
          edge_req.rd_addr = {cur, issue_idx};
          node_req.rd_en   = 1'b1;
          node_req.rd_addr = issue_idx;
          b_valid_next     = 1'b1;
          x_b_next         = issue_idx;
          if (issue_idx == LAST_NODE) begin
            issue_done_next = 1'b1;
          end else begin
            issue_idx_next = issue_idx + 1'b1;
          end
        end
        if (upd) begin
          node_req.wr_en            = 1'b1;
          node_req.wr_addr          = x_b;
          node_req.wr_data.distance = sum_sat;
          node_req.wr_data.pred     = cur;
          valid_mask_next[x_b]  = 1'b1;
        end
        best_next      = best_now;
        found_next     = found_now;
        next_node_next = next_now;
        if (pass_end) begin
          visited_next = visited | one_hot_cur;
          if (found_now) begin
            cur_next        = next_now;
            cur_dist_next   = best_now;
            issue_idx_next  = '0;
            issue_done_next = 1'b0;
            best_next       = reach_limit;
            found_next      = 1'b0;
          end else begin
            out_idx_next = '0;
            state_next   = S_OUT_RD;
          end
        end
      end
      S_OUT_RD: begin
        node_req.rd_en   = 1'b1;
        node_req.rd_addr = out_idx;
        state_next       = S_OUT_WR;
      end
      S_OUT_WR: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          if (out_idx == LAST_NODE) begin
            state_next = S_IDLE;
          end else begin
            out_idx_next = out_idx + 1'b1;
            state_next   = S_OUT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur        <= '0;
      issue_done <= 1'b1;
      b_valid    <= 1'b0;
      found      <= 1'b0;
      visited    <= '0;
      valid_mask <= '0;
      out_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      issue_done <= issue_done_next;
      b_valid    <= b_valid_next;
      found      <= found_next;
      visited    <= visited_next;
      valid_mask <= valid_mask_next;
      out_idx    <= out_idx_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_dist  <= cur_dist_next;
    issue_idx <= issue_idx_next;
    x_b       <= x_b_next;
    best      <= best_next;
    next_node <= next_node_next;
    if (out_load) begin
      node        <= out_idx;
      distance    <= valid_mask[out_idx] ? node_rd.distance : DIST_MAX;
      predecessor <= valid_mask[out_idx] ? node_rd.pred : '0;
      reached     <= valid_mask[out_idx] && (node_rd.distance != DIST_MAX);
      last        <= (out_idx == LAST_NODE);
    end
  end

endmodule

>>> hdl/dense_shortest_path_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_shortest_path_search
// Single-source shortest paths over a 16 x 16 adjacency matrix in memory.
// ----------------------------------------------------------------------------
// An edge load word is written to the edge memory when it is accepted. A run
// word settles one node per pass, reading that node's row through the edge
// memory read port one entry per cycle, with between 1 and 16 such passes,
// and then reports all 16 nodes in index order, each result read through the
// node memory port; out_stall holds the report back.
// The input stays stalled from the accepted run word until the last result
// has been loaded into the output. The last result carries last.
// Write reach_limit only while the block is idle.
// ----------------------------------------------------------------------------
module dense_shortest_path_search
  import dsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  dist_t     cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      action,
  input  node_idx_t from_node,
  input  node_idx_t to_node,
  input  weight_t   edge_weight,
  input  logic      edge_present,
  input  node_idx_t start_node,
  output logic      out_valid,
  input  logic      out_stall,
  output node_idx_t node,
  output dist_t     distance,
  output node_idx_t predecessor,
  output logic      reached,
  output logic      last
);

  dist_t         reach_limit;
  edge_ram_req_t edge_req;
  edge_entry_t   edge_rd;
  node_ram_req_t node_req;
  node_entry_t   node_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_limit <= REACH_LIMIT_RESET;
    end else if (cfg_write) begin
      reach_limit <= cfg_data;
    end
  end

  dsp_edge_ram u_edge_ram (
    .clk     (clk),
    .req     (edge_req),
    .rd_data (edge_rd)
  );

  dsp_node_ram u_node_ram (
    .clk     (clk),
    .req     (node_req),
    .rd_data (node_rd)
  );

  dsp_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .reach_limit  (reach_limit),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .from_node    (from_node),
    .to_node      (to_node),
    .edge_weight  (edge_weight),
    .edge_present (edge_present),
    .start_node   (start_node),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .node         (node),
    .distance     (distance),
    .predecessor  (predecessor),
    .reached      (reached),
    .last         (last),
    .edge_req     (edge_req),
    .edge_rd      (edge_rd),
    .node_req     (node_req),
    .node_rd      (node_rd)
  );

endmodule

>>> hdl/dsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks for the shortest path search, bound to the top level.
// ----------------------------------------------------------------------------
module dsp_checker
  import dsp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input node_idx_t node,
  input dist_t     distance,
  input node_idx_t predecessor,
  input logic      reached,
  input logic      last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node) && $stable(distance))
    else $error("stalled output word changed");

  a_reached_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reached == (distance != DIST_MAX)))
    else $error("reached flag disagrees with distance");

  a_unreached_pred: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reached |-> predecessor == '0)
    else $error("unreached node reports a predecessor");

  a_last_node: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (node == LAST_NODE)))
    else $error("last flag on the wrong node");

  // While any word but the final one of a report waits, the input stays closed.
  a_busy_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input opened before the report finished");

endmodule

bind dense_shortest_path_search dsp_checker u_dsp_checker (.*);
